FILE: rtl/pps_pkg.sv
// shared types, constants and helpers for the preemptive priority scheduler
// no dependencies; imported by every module of the block
package pps_pkg;

  localparam int NumSlots = 16;
  localparam logic [23:0] T24Max = 24'hFF_FFFF;
  localparam logic [15:0] C16Max = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_SWITCH = 2'd0,
    KIND_RUN    = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_QUERY  = 2'd3
  } kind_e;

  typedef struct packed {
    cmd_e        command;
    logic [3:0]  slot;
    logic [7:0]  task_id;
    logic [15:0] arrival_time;
    logic [15:0] burst_length;
    logic [7:0]  priority_level;
  } pps_req_t;

  typedef struct packed {
    kind_e       kind;
    logic [23:0] start_time;
    logic [23:0] end_time;
    logic [7:0]  run_task_id;
    logic [23:0] finish_time;
    logic [15:0] switch_count;
    logic [23:0] switch_ticks;
    logic [23:0] current_time;
    logic        last;
  } pps_rsp_t;

  // one task slot as it travels around the ring
  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] arr;
    logic [15:0] burst;
    logic [7:0]  pri;
    logic [15:0] rem;
    logic [23:0] fin;
  } pps_rec_t;

  function automatic logic [23:0] sat_add24(input logic [23:0] a, input logic [23:0] b);
    logic [24:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[24] ? T24Max : s[23:0];
  endfunction

endpackage

FILE: rtl/pps_cell.sv
// one slot cell of the scheduler ring: holds a task record, shifts it on
// depends on pps_pkg
module pps_cell import pps_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     shift_i,
  input  pps_rec_t rec_i,
  output pps_rec_t rec_o
);

  pps_rec_t rec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else if (shift_i) begin
      rec_q <= rec_i;
    end
  end

  assign rec_o = rec_q;

endmodule

FILE: rtl/preemptive_priority_scheduler_top.sv
// preemptive priority scheduler: ring of slot cells plus head control
// depends on pps_pkg and pps_cell
//
// Usage: requests enter on req_valid_i/req_ready_o as pps_req_t; results
// leave on rsp_valid_o/rsp_ready_i as pps_rsp_t, last set on the final one.
// switch_cost is written through cfg_we_i/cfg_wdata_i; the user must write
// it only while idle, the block itself has no guard for it. The slot records
// circulate around a ring of NUM_SLOTS cells; the cell at the head is read
// and rewritten once per cycle, so every request takes one full rotation of
// the ring. A step that runs a task takes a second rotation to write the
// chosen slot back; its run record follows the sweep, the decide state and
// the write-back rotation, and the next request is accepted once that record
// is taken. Load and start return to idle after their rotation; a query
// reply and an all-done record are registered in the decide state after it.
// One request is in flight at a time; req_ready_o is high only when the
// block is idle and the output register is empty. A switch record is shown
// during the write-back rotation, the run record after it once the output
// register is free. A stalled receiver holds the block in that state.
// Reset clears all slots, time and totals, sets switch_cost to 1.
module preemptive_priority_scheduler_top import pps_pkg::*; #(
  parameter int NUM_SLOTS = NumSlots
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  pps_req_t   req_i,
  output logic       rsp_valid_o,
  input  logic       rsp_ready_i,
  output pps_rsp_t   rsp_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = (IW > 4) ? IW : 4;
  localparam logic [IW-1:0] LastPos = IW'(NUM_SLOTS - 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SWEEP  = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_APPLY  = 5'b01000,
    ST_RUN    = 5'b10000
  } state_e;

  state_e state_q, state_d;
  pps_req_t req_q;
  logic [IW-1:0] pos_q, pos_d;
  logic [7:0] cost_q;
  logic [23:0] now_q, now_d;
  logic [15:0] swc_q, swc_d;
  logic [23:0] swt_q, swt_d;
  logic run_v_q, run_v_d;
  logic [IW-1:0] run_idx_q, run_idx_d;
  logic act_q, act_d;
  logic bv_q, bv_d;
  logic [IW-1:0] bidx_q, bidx_d;
  logic [7:0] bid_q, bid_d, bpri_q, bpri_d;
  logic [15:0] brem_q, brem_d;
  logic [23:0] bfin_q, bfin_d;
  logic [7:0] qid_q, qid_d;
  logic [23:0] qfin_q, qfin_d;
  logic rsp_valid_q, rsp_valid_d;
  pps_rsp_t rsp_q, rsp_d;

  pps_rec_t ring [NUM_SLOTS];
  pps_rec_t head_new;
  logic shift;
  logic slot_hit;
  logic out_free;
  logic [23:0] now_inc;

  assign shift = (state_q == ST_SWEEP) || (state_q == ST_APPLY);
  assign slot_hit = (CW'(req_q.slot) == CW'(pos_q));
  assign out_free = !rsp_valid_q || rsp_ready_i;
  assign now_inc = sat_add24(now_q, 24'd1);

  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
    pps_rec_t cell_in;
    if (k == NUM_SLOTS - 1) begin : g_tail
      assign cell_in = head_new;
    end else begin : g_mid
      assign cell_in = ring[k+1];
    end
    pps_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .rec_i  (cell_in),
      .rec_o  (ring[k])
    );
  end

  // rewrite of the record leaving the head
  always_comb begin
    head_new = ring[0];
    if (state_q == ST_SWEEP) begin
      case (req_q.command)
        CMD_LOAD: begin
          if (slot_hit) begin
            head_new.id    = req_q.task_id;
            head_new.arr   = req_q.arrival_time;
            head_new.burst = req_q.burst_length;
            head_new.pri   = req_q.priority_level;
          end
        end
        CMD_START: begin
          head_new.rem = ring[0].burst;
          head_new.fin = '0;
        end
        default: ;
      endcase
    end else if (state_q == ST_APPLY && pos_q == bidx_q) begin
      head_new.rem = ring[0].rem - 16'd1;
      if (ring[0].rem == 16'd1) head_new.fin = now_inc;
    end
  end

  always_comb begin
    state_d = state_q;
    pos_d = pos_q;
    now_d = now_q;
    swc_d = swc_q;
    swt_d = swt_q;
    run_v_d = run_v_q;
    run_idx_d = run_idx_q;
    act_d = act_q;
    bv_d = bv_q;
    bidx_d = bidx_q;
    bid_d = bid_q;
    bpri_d = bpri_q;
    brem_d = brem_q;
    bfin_d = bfin_q;
    qid_d = qid_q;
    qfin_d = qfin_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    rsp_d = rsp_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i && req_ready_o) begin
          state_d = ST_SWEEP;
          pos_d = '0;
          act_d = 1'b0;
          bv_d = 1'b0;
          qid_d = '0;
          qfin_d = '0;
        end
      end
      ST_SWEEP: begin
        if (req_q.command == CMD_QUERY && slot_hit) begin
          qid_d = ring[0].id;
          qfin_d = ring[0].fin;
        end
        if (req_q.command == CMD_STEP && ring[0].rem != '0) begin
          act_d = 1'b1;
          if ({8'd0, ring[0].arr} <= now_q &&
              (!bv_q || ring[0].pri < bpri_q ||
               (ring[0].pri == bpri_q && ring[0].id < bid_q))) begin
            bv_d = 1'b1;
            bidx_d = pos_q;
            bid_d = ring[0].id;
            bpri_d = ring[0].pri;
            brem_d = ring[0].rem;
            bfin_d = ring[0].fin;
          end
        end
        pos_d = pos_q + 1'b1;
        if (pos_q == LastPos) begin
          pos_d = '0;
          state_d = (req_q.command == CMD_STEP || req_q.command == CMD_QUERY)
                    ? ST_DECIDE : ST_IDLE;
        end
      end
      ST_DECIDE: begin
        state_d = ST_IDLE;
        rsp_d = '0;
        rsp_d.switch_count = swc_q;
        rsp_d.switch_ticks = swt_q;
        rsp_d.current_time = now_q;
        rsp_d.last = 1'b1;
        if (req_q.command == CMD_QUERY) begin
          rsp_valid_d = 1'b1;
          rsp_d.kind = KIND_QUERY;
          rsp_d.run_task_id = qid_q;
          rsp_d.finish_time = qfin_q;
        end else if (!act_q) begin
          rsp_valid_d = 1'b1;
          rsp_d.kind = KIND_DONE;
        end else if (!bv_q) begin
          now_d = now_inc;
        end else begin
          state_d = ST_APPLY;
          if (!(run_v_q && run_idx_q == bidx_q)) begin
            now_d = sat_add24(now_q, {16'd0, cost_q});
            swc_d = (swc_q == C16Max) ? swc_q : swc_q + 16'd1;
            swt_d = sat_add24(swt_q, {16'd0, cost_q});
            rsp_valid_d = 1'b1;
            rsp_d.kind = KIND_SWITCH;
            rsp_d.start_time = now_q;
            rsp_d.end_time = (cost_q == '0) ? now_q
                             : sat_add24(now_q, {16'd0, cost_q - 8'd1});
            rsp_d.run_task_id = bid_q;
            rsp_d.finish_time = bfin_q;
            rsp_d.switch_count = swc_d;
            rsp_d.switch_ticks = swt_d;
            rsp_d.current_time = now_d;
            rsp_d.last = 1'b0;
          end
        end
      end
      ST_APPLY: begin
        pos_d = pos_q + 1'b1;
        if (pos_q == LastPos) begin
          pos_d = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (out_free) begin
          state_d = ST_IDLE;
          now_d = now_inc;
          run_v_d = (brem_q != 16'd1);
          run_idx_d = bidx_q;
          rsp_valid_d = 1'b1;
          rsp_d.kind = KIND_RUN;
          rsp_d.start_time = now_q;
          rsp_d.end_time = now_q;
          rsp_d.run_task_id = bid_q;
          rsp_d.finish_time = (brem_q == 16'd1) ? now_inc : bfin_q;
          rsp_d.switch_count = swc_q;
          rsp_d.switch_ticks = swt_q;
          rsp_d.current_time = now_inc;
          rsp_d.last = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (state_q == ST_IDLE && req_valid_i && req_ready_o &&
        req_i.command == CMD_START) begin
      now_d = '0;
      swc_d = '0;
      swt_d = '0;
      run_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q <= '0;
      cost_q <= 8'd1;
      now_q <= '0;
      swc_q <= '0;
      swt_q <= '0;
      run_v_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q <= pos_d;
      if (cfg_we_i) cost_q <= cfg_wdata_i;
      now_q <= now_d;
      swc_q <= swc_d;
      swt_q <= swt_d;
      run_v_q <= run_v_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && req_valid_i && req_ready_o) req_q <= req_i;
    run_idx_q <= run_idx_d;
    act_q <= act_d;
    bv_q <= bv_d;
    bidx_q <= bidx_d;
    bid_q <= bid_d;
    bpri_q <= bpri_d;
    brem_q <= brem_d;
    bfin_q <= bfin_d;
    qid_q <= qid_d;
    qfin_q <= qfin_d;
    rsp_q <= rsp_d;
  end

  assign req_ready_o = (state_q == ST_IDLE) && !rsp_valid_q;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o = rsp_q;

endmodule

FILE: rtl/pps_checker.sv
// port-level checks for the preemptive priority scheduler, bound to the top
// depends on pps_pkg and preemptive_priority_scheduler_top
module pps_checker import pps_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_o,
  input pps_req_t   req_i,
  input logic       rsp_valid_o,
  input logic       rsp_ready_i,
  input pps_rsp_t   rsp_o,
  input logic       cfg_we_i,
  input logic [7:0] cfg_wdata_i
);

  // a pending result is never dropped
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o)
    else $error("result dropped while stalled");

  // one request at a time: busy right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> !req_ready_o)
    else $error("request accepted while busy");

  // a switch record is never the last one: its run record always follows
  a_switch_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.kind == KIND_SWITCH |-> !rsp_o.last)
    else $error("switch record marked last");

  a_run_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.kind == KIND_RUN |->
      rsp_o.last && rsp_o.start_time == rsp_o.end_time)
    else $error("bad run record");

  // the block is never ready while a result waits
  a_ready_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !req_ready_o)
    else $error("ready with result pending");

endmodule

bind preemptive_priority_scheduler_top pps_checker u_pps_checker (.*);
